// ===== design/mdcb_pkg.sv =====
// Shared types and constants for the microphone DC blocker, gain and silence stop block.
package mdcb_pkg;

	localparam logic [1:0] CMD_START     = 2'd0;
	localparam logic [1:0] CMD_SAMPLE    = 2'd1;
	localparam logic [1:0] CMD_FRAME_END = 2'd2;
	localparam logic [1:0] CMD_TICK      = 2'd3;

	localparam logic [1:0] STOP_NONE    = 2'd0;
	localparam logic [1:0] STOP_FULL    = 2'd1;
	localparam logic [1:0] STOP_SILENCE = 2'd2;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN          = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_EN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_THR   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_MS    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEECH_MS = 3'd5;

	localparam logic [15:0] GAIN_RESET = 16'd256;
	localparam logic [15:0] GAIN_MIN   = 16'd26;
	localparam logic [14:0] POLE_Q15   = 15'd32604;
	localparam logic [19:0] CNT_MAX    = 20'hFFFFF;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] slot_word;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pcm_sample;
		logic               sample_valid;
		logic               is_recording;
		logic [1:0]         stop_cause;
		logic [15:0]        frame_peak;
		logic               speech_seen;
	} out_item_t;

	typedef struct packed {
		logic [15:0] gain_q8_8;
		logic [19:0] capacity_samples;
		logic        silence_enable;
		logic [15:0] silence_threshold;
		logic [19:0] silence_ms;
		logic [19:0] min_speech_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [23:0] x;
	} q_item_t;

endpackage

// ===== design/mic_dc_block_gain_silence_stop_top.sv =====
// Top level of the microphone DC blocker, gain and silence stop recorder.
//
//   channel   handshake               payload
//   in        in_valid / in_stall     in_item  (command, slot_word)
//   out       out_valid / out_stall   out_item (pcm_sample .. speech_seen)
//   config    cfg_wr_en               cfg_index, cfg_data
//
// Start, frame end, tick and ignored samples are handled in the dispatch step.
// A recorded sample passes five steps: dispatch, pole multiply, filter sum and
// clamp, gain multiply, scale and saturate; no new item is popped meanwhile.
// The input queue holds QUEUE_DEPTH items, so the front keeps taking items
// while the back end works or the result register waits on out_stall.
// Reset clears the queue, the filter, the counters and loads register defaults.
module mic_dc_block_gain_silence_stop_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  mdcb_pkg::in_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output mdcb_pkg::out_item_t                    out_item,
	input  logic                                   cfg_wr_en,
	input  logic [mdcb_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [mdcb_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import mdcb_pkg::*;

	cfg_t    cfg_q;
	logic    head_valid;
	q_item_t head;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_q8_8         <= GAIN_RESET;
			cfg_q.capacity_samples  <= CNT_MAX;
			cfg_q.silence_enable    <= 1'b0;
			cfg_q.silence_threshold <= '0;
			cfg_q.silence_ms        <= '0;
			cfg_q.min_speech_ms     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIN:          cfg_q.gain_q8_8         <= cfg_data[15:0];
				REG_CAPACITY:      cfg_q.capacity_samples  <= cfg_data;
				REG_SILENCE_EN:    cfg_q.silence_enable    <= cfg_data[0];
				REG_SILENCE_THR:   cfg_q.silence_threshold <= cfg_data[15:0];
				REG_SILENCE_MS:    cfg_q.silence_ms        <= cfg_data;
				REG_MIN_SPEECH_MS: cfg_q.min_speech_ms     <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	mdcb_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mdcb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

// ===== design/mdcb_front.sv =====
// Front end: accepts items, extracts the 24-bit audio value and queues them for the back end.
module mdcb_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mdcb_pkg::in_item_t in_item,
	input  logic               pop,
	output logic               head_valid,
	output mdcb_pkg::q_item_t  head
);
	import mdcb_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	q_item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 push;
	q_item_t              entry;

	assign in_stall   = (count_q == CNT_W'(DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_comb begin
		entry.cmd = in_item.command;
		entry.x   = in_item.slot_word[31:8];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/mdcb_back.sv =====
// Back end: runs the filter, gain, counters and stop rules and holds the result register.
module mdcb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mdcb_pkg::cfg_t      cfg,
	input  logic                head_valid,
	input  mdcb_pkg::q_item_t   head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output mdcb_pkg::out_item_t out_item
);
	import mdcb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POLE = 3'd1;
	localparam logic [2:0] ST_HP   = 3'd2;
	localparam logic [2:0] ST_GAIN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]         state_q;
	logic               rec_q;
	logic signed [23:0] prev_x_q;
	logic signed [41:0] prev_hp_q;
	logic [19:0]        count_q;
	logic [15:0]        peak_q;
	logic               speech_q;
	logic [19:0]        ms_start_q;
	logic [19:0]        ms_voice_q;

	logic signed [23:0] x_s1;
	logic signed [56:0] pole_s2;
	logic signed [41:0] hp_s3;
	logic signed [58:0] gprod_s4;

	logic               out_valid_q;
	out_item_t          out_q;

	logic               out_free;
	logic               out_load;
	logic               start_sample;
	logic [15:0]        gain_eff;
	logic signed [24:0] diff;
	logic signed [42:0] hp_sum;
	logic signed [41:0] hp_sat;
	logic signed [58:0] gprod_adj;
	logic signed [27:0] gquot;
	logic signed [15:0] pcm_fin;
	logic [15:0]        mag;
	logic [15:0]        peak_fin;
	logic [19:0]        count_inc;
	logic               full_fin;
	logic               fe_active;
	logic               fe_loud;
	logic               fe_speech;
	logic [19:0]        fe_voice;
	logic               fe_stop;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign start_sample = (head.cmd == CMD_SAMPLE) && rec_q
		&& (count_q < cfg.capacity_samples);
	assign pop = (state_q == ST_IDLE) && head_valid && (start_sample || out_free);
	assign out_load = ((state_q == ST_IDLE) && pop && !start_sample)
		|| ((state_q == ST_FIN) && out_free);

	assign gain_eff = (cfg.gain_q8_8 < GAIN_MIN) ? GAIN_MIN : cfg.gain_q8_8;

	always_comb begin
		diff   = {x_s1[23], x_s1} - {prev_x_q[23], prev_x_q};
		hp_sum = {{3{diff[24]}}, diff, 15'd0} + {pole_s2[56], pole_s2[56:15]};
		if (hp_sum[42] != hp_sum[41]) begin
			hp_sat = hp_sum[42] ? {1'b1, 41'd0} : {1'b0, {41{1'b1}}};
		end else begin
			hp_sat = hp_sum[41:0];
		end
	end

	always_comb begin
		gprod_adj = gprod_s4 + (gprod_s4[58] ? 59'sh7FFFFFFF : 59'sd0);
		gquot     = gprod_adj[58:31];
		if (gquot > 28'sd32767) begin
			pcm_fin = 16'sh7FFF;
		end else if (gquot < -28'sd32768) begin
			pcm_fin = 16'sh8000;
		end else begin
			pcm_fin = gquot[15:0];
		end
		mag       = pcm_fin[15] ? 16'(-pcm_fin) : pcm_fin;
		peak_fin  = (mag > peak_q) ? mag : peak_q;
		count_inc = count_q + 1'b1;
		full_fin  = (count_inc >= cfg.capacity_samples);
	end

	always_comb begin
		fe_active = rec_q && cfg.silence_enable;
		fe_loud   = fe_active && (peak_q >= cfg.silence_threshold);
		fe_speech = speech_q || fe_loud;
		fe_voice  = fe_loud ? '0 : ms_voice_q;
		fe_stop   = fe_active && fe_speech && (ms_start_q >= cfg.min_speech_ms)
			&& (fe_voice >= cfg.silence_ms);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (pop) begin
				x_s1 <= head.x;
			end
			pole_s2 <= prev_hp_q * $signed({1'b0, POLE_Q15});
		end
		if (state_q == ST_POLE) begin
			hp_s3 <= hp_sat;
		end
		if (state_q == ST_GAIN) begin
			gprod_s4 <= hp_s3 * $signed({1'b0, gain_eff});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rec_q       <= 1'b0;
			prev_x_q    <= '0;
			prev_hp_q   <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			speech_q    <= 1'b0;
			ms_start_q  <= '0;
			ms_voice_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (start_sample) begin
							state_q <= ST_POLE;
						end else begin
							out_q.pcm_sample   <= '0;
							out_q.sample_valid <= 1'b0;
							unique case (head.cmd)
								CMD_START: begin
									rec_q      <= 1'b1;
									prev_x_q   <= '0;
									prev_hp_q  <= '0;
									count_q    <= '0;
									peak_q     <= '0;
									speech_q   <= 1'b0;
									ms_start_q <= '0;
									ms_voice_q <= '0;
									out_q.is_recording <= 1'b1;
									out_q.stop_cause   <= STOP_NONE;
									out_q.frame_peak   <= '0;
									out_q.speech_seen  <= 1'b0;
								end
								CMD_SAMPLE: begin
									rec_q <= 1'b0;
									out_q.is_recording <= 1'b0;
									out_q.stop_cause   <= rec_q ? STOP_FULL : STOP_NONE;
									out_q.frame_peak   <= peak_q;
									out_q.speech_seen  <= speech_q;
								end
								CMD_FRAME_END: begin
									speech_q   <= fe_speech;
									ms_voice_q <= fe_voice;
									rec_q      <= rec_q && !fe_stop;
									peak_q     <= '0;
									out_q.is_recording <= rec_q && !fe_stop;
									out_q.stop_cause   <= fe_stop ? STOP_SILENCE : STOP_NONE;
									out_q.frame_peak   <= peak_q;
									out_q.speech_seen  <= fe_speech;
								end
								CMD_TICK: begin
									if (ms_start_q != CNT_MAX) begin
										ms_start_q <= ms_start_q + 1'b1;
									end
									if (ms_voice_q != CNT_MAX) begin
										ms_voice_q <= ms_voice_q + 1'b1;
									end
									out_q.is_recording <= rec_q;
									out_q.stop_cause   <= STOP_NONE;
									out_q.frame_peak   <= peak_q;
									out_q.speech_seen  <= speech_q;
								end
								default: begin
									out_q.is_recording <= rec_q;
									out_q.stop_cause   <= STOP_NONE;
									out_q.frame_peak   <= peak_q;
									out_q.speech_seen  <= speech_q;
								end
							endcase
						end
					end
				end
				ST_POLE: begin
					state_q <= ST_HP;
				end
				ST_HP: begin
					prev_x_q  <= x_s1;
					prev_hp_q <= hp_sat;
					state_q   <= ST_GAIN;
				end
				ST_GAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						peak_q  <= peak_fin;
						count_q <= count_inc;
						rec_q   <= !full_fin;
						state_q <= ST_IDLE;
						out_q.pcm_sample   <= pcm_fin;
						out_q.sample_valid <= 1'b1;
						out_q.is_recording <= !full_fin;
						out_q.stop_cause   <= full_fin ? STOP_FULL : STOP_NONE;
						out_q.frame_peak   <= peak_fin;
						out_q.speech_seen  <= speech_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
